// ===== rtl/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to UCS-2 decoder.
`default_nettype none

package u8dec_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 16;
    localparam int PENDING_W = 2;
    localparam int PARTIAL_W = 10;
    localparam int CONT_W    = 6;

    // Top nibbles of lead bytes
    localparam logic [3:0] NIB_LEAD4  = 4'hF;
    localparam logic [3:0] NIB_LEAD3  = 4'hE;
    localparam logic [3:0] NIB_LEAD2A = 4'hC;
    localparam logic [3:0] NIB_LEAD2B = 4'hD;

    localparam logic [PENDING_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PENDING_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PENDING_W-1:0] PEND_TWO  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              first_of_string;
    } u8dec_in_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            unsupported_lead;
    } u8dec_out_t;

    typedef struct packed {
        logic [PENDING_W-1:0] bytes_pending;
        logic [PARTIAL_W-1:0] partial_value;
        logic                 string_aborted;
    } u8dec_state_t;

endpackage

`default_nettype wire

// ===== rtl/utf8_to_ucs2_decoder_core.sv =====
// Top level of the UTF-8 to UCS-2 decoder: handshake, sequence state, result buffer.
`default_nettype none

// UTF-8 to UCS-2 decoder. One UTF-8 byte per request on the s_ channel; one
// 16-bit code point per completed character on the m_ channel. ASCII bytes
// come out as they are, two- and three-byte sequences come out after their
// last byte, a four-byte lead gives one result with code_point 0 and
// unsupported_lead set and then drops every byte until first_of_string.
// Stray continuation bytes give nothing. first_of_string resets any pending
// sequence and abort before its byte is decoded.
// Throughput: one byte per clock while s_ready is high. The decode is a single
// combinational pass from the accepted byte and the state registers into a
// two-entry result buffer: the output register, or the skid register on a stall.
// s_ready drops only when both entries are full, i.e. after the sink has
// stalled for two results in a row.
module utf8_to_ucs2_decoder_core
    import u8dec_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,

    input  wire              s_valid,
    output logic             s_ready,
    input  wire u8dec_in_t   s_data,

    output logic             m_valid,
    input  wire              m_ready,
    output u8dec_out_t       m_data
);

    // Sequence state, updated on every accepted request
    u8dec_state_t state_reg;
    u8dec_state_t state_next;

    // Result buffer: out entry drives m_, skid entry catches a result that
    // arrives while the out entry is stalled
    u8dec_out_t out_reg;
    logic       out_valid_reg;
    u8dec_out_t skid_reg;
    logic       skid_valid_reg;

    logic       res_valid;
    u8dec_out_t res;
    logic       accept;
    logic       pop;
    logic       push;

    u8dec_step u_step (
        .item       (s_data),
        .cur_state  (state_reg),
        .next_state (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign accept = s_valid && s_ready;
    assign pop    = out_valid_reg && m_ready;
    assign push   = accept && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end

            if (skid_valid_reg) begin
                // no request taken this cycle; drain skid into out
                if (pop) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_valid_reg || pop) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8dec_step.sv =====
// Per-byte decode: next sequence state and the optional result for one byte.
`default_nettype none

module u8dec_step
    import u8dec_pkg::*;
(
    input  wire u8dec_in_t    item,
    input  wire u8dec_state_t cur_state,
    output u8dec_state_t      next_state,
    output logic              res_valid,
    output u8dec_out_t        res
);

    u8dec_state_t    st;
    logic [CP_W-1:0] cp;
    logic [BYTE_W-1:0] b;

    always_comb begin
        b  = item.in_byte;
        st = item.first_of_string ? '0 : cur_state;
        cp = {st.partial_value, b[CONT_W-1:0]};

        next_state = st;
        res_valid  = 1'b0;
        res        = '0;

        if (!st.string_aborted) begin
            if (st.bytes_pending != PEND_NONE) begin
                // continuation: top bits are not checked
                next_state.bytes_pending = st.bytes_pending - PEND_ONE;
                if (st.bytes_pending != PEND_ONE) begin
                    next_state.partial_value = cp[PARTIAL_W-1:0];
                end else begin
                    next_state.partial_value = '0;
                    res_valid                = 1'b1;
                    res.code_point           = cp;
                end
            end else if (!b[BYTE_W-1]) begin
                res_valid      = 1'b1;
                res.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
            end else begin
                case (b[7:4])
                    NIB_LEAD4: begin
                        next_state.string_aborted = 1'b1;
                        res_valid                 = 1'b1;
                        res.unsupported_lead      = 1'b1;
                    end
                    NIB_LEAD3: begin
                        next_state.partial_value = {{(PARTIAL_W-4){1'b0}}, b[3:0]};
                        next_state.bytes_pending = PEND_TWO;
                    end
                    NIB_LEAD2A, NIB_LEAD2B: begin
                        next_state.partial_value = {{(PARTIAL_W-5){1'b0}}, b[4:0]};
                        next_state.bytes_pending = PEND_ONE;
                    end
                    default: begin
                        // stray continuation byte: dropped
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/utf8_to_ucs2_decoder_core_tb.sv =====
// Self-checking testbench for the UTF-8 to UCS-2 decoder core: directed and random byte streams.
module utf8_to_ucs2_decoder_core_tb
    import u8dec_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous cycle budget.
    localparam int LIMIT_CYCLES = 400000;
    // Cycles to let pass after the last expected character: result buffer depth plus margin.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 325;
    // Prefix of a UTF-8 continuation byte.
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Decoding model plus the queue of characters it expects from the block.
    class ucs2_scoreboard;
        logic [PENDING_W-1:0] pend    = PEND_NONE;
        logic [PARTIAL_W-1:0] partial = '0;
        logic                 aborted = 1'b0;
        u8dec_out_t           expected_chars[$];

        // Append one character to the expected queue.
        function void add_char(u8dec_out_t ch);
            expected_chars = {expected_chars, ch};
        endfunction

        // Advance the model by one accepted request; queue a character if one completes.
        function void note_byte(u8dec_in_t req);
            logic [BYTE_W-1:0] b;
            logic [CP_W-1:0]   cp;
            u8dec_out_t        ch;
            b = req.in_byte;
            if (req.first_of_string) begin
                pend    = PEND_NONE;
                partial = '0;
                aborted = 1'b0;
            end
            if (aborted) begin
                return;
            end
            // Inside a sequence every byte counts as a continuation, top bits ignored.
            if (pend != PEND_NONE) begin
                cp   = {partial, b[CONT_W-1:0]};
                pend = pend - 1'b1;
                if (pend != PEND_NONE) begin
                    partial = cp[PARTIAL_W-1:0];
                    return;
                end
                partial = '0;
                ch.code_point       = cp;
                ch.unsupported_lead = 1'b0;
                add_char(ch);
                return;
            end
            if (!b[BYTE_W-1]) begin
                ch.code_point       = CP_W'(b);
                ch.unsupported_lead = 1'b0;
                add_char(ch);
                return;
            end
            case (b[7:4])
                NIB_LEAD4: begin
                    aborted             = 1'b1;
                    ch.code_point       = '0;
                    ch.unsupported_lead = 1'b1;
                    add_char(ch);
                end
                NIB_LEAD3: begin
                    partial = PARTIAL_W'(b[3:0]);
                    pend    = PEND_TWO;
                end
                NIB_LEAD2A, NIB_LEAD2B: begin
                    partial = PARTIAL_W'(b[4:0]);
                    pend    = PEND_ONE;
                end
                default: ;  // stray continuation: nothing
            endcase
        endfunction

        // Compare one accepted result with the oldest expected character.
        // Empty string means it matched.
        function string check_char(u8dec_out_t got);
            u8dec_out_t want;
            string      why;
            why = "";
            if (expected_chars.size() == 0) begin
                return $sformatf("unexpected result code_point=%h unsupported_lead=%b",
                                 got.code_point, got.unsupported_lead);
            end
            want = expected_chars.pop_front();
            if (got.code_point !== want.code_point) begin
                why = {why, $sformatf("code_point %h, want %h; ",
                                      got.code_point, want.code_point)};
            end
            if (got.unsupported_lead !== want.unsupported_lead) begin
                why = {why, $sformatf("unsupported_lead %b, want %b; ",
                                      got.unsupported_lead, want.unsupported_lead)};
            end
            return why;
        endfunction

        function int outstanding();
            return expected_chars.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    u8dec_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    u8dec_out_t m_data;

    ucs2_scoreboard sb = new;

    int  mismatches   = 0;
    int  cycles       = 0;
    int  items_sent   = 0;
    int  src_idle_pct = 0;   // chance per cycle that the sender holds off
    int  snk_stall_pct = 0;  // chance per cycle that the sink stalls
    int  src_burst    = 0;   // requests left in a no-idle stretch
    int  snk_burst    = 0;   // cycles left in a no-stall stretch
    logic force_first = 1'b0;

    utf8_to_ucs2_decoder_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("utf8_to_ucs2_decoder_core_tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Both handshakes sampled at the rising edge. A request accepted at this edge
    // cannot have its character on m_ at the same edge, so the order here is free.
    always @(posedge aclk) begin
        string why;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_byte(s_data);
            end
            if (m_valid && m_ready) begin
                why = sb.check_char(m_data);
                if (why != "") begin
                    report_mismatch(why);
                end
            end
        end
    end

    // Sink: m_ready changes at the falling edge only, one assignment per edge.
    // Random no-stall stretches keep some back-to-back acceptance in every phase.
    always @(negedge aclk) begin
        if (snk_burst > 0) begin
            snk_burst <= snk_burst - 1;
            m_ready   <= 1'b1;
        end else begin
            if ($urandom_range(39) == 0) begin
                snk_burst <= 25;
            end
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Idle cycles before the next request; capped so a long run of holds cannot stall.
    function automatic int src_gap();
        int g;
        g = 0;
        if (src_burst > 0) begin
            src_burst--;
            return 0;
        end
        if ($urandom_range(49) == 0) begin
            src_burst = 20;
        end
        while (g < 30 && $urandom_range(99) < src_idle_pct) begin
            g++;
        end
        return g;
    endfunction

    // Drive one request; entered and left at a falling edge. Valid is only lowered
    // when a gap follows, so it never drops and rises within one time step.
    task automatic put(logic [BYTE_W-1:0] b, logic fos);
        int gap;
        gap = src_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid                <= 1'b1;
        s_data.in_byte         <= b;
        s_data.first_of_string <= fos;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // Mostly a proper continuation with random payload, sometimes any byte at all.
    function automatic logic [BYTE_W-1:0] cont_byte();
        if ($urandom_range(7) == 0) begin
            return BYTE_W'($urandom);
        end
        return {CONT_TAG, CONT_W'($urandom_range(63))};
    endfunction

    // One random character or piece of noise. Mostly well-formed sequences with
    // random content; the rest are aborts, stray and truncated sequences, raw bytes.
    task automatic send_random_unit();
        int   kind;
        int   n;
        logic fos;
        kind = $urandom_range(99);
        fos  = force_first || ($urandom_range(15) == 0);
        force_first = 1'b0;
        if (kind < 30) begin
            put(BYTE_W'($urandom_range(127)), fos);
        end else if (kind < 55) begin
            put({NIB_LEAD2A[3:1], 5'($urandom_range(31))}, fos);
            put(cont_byte(), 1'b0);
        end else if (kind < 75) begin
            put({NIB_LEAD3, 4'($urandom_range(15))}, fos);
            put(cont_byte(), 1'b0);
            put(cont_byte(), 1'b0);
        end else if (kind < 80) begin
            // Abort, up to three dropped bytes, then a fresh string.
            put({NIB_LEAD4, 4'($urandom_range(15))}, fos);
            n = $urandom_range(3);
            repeat (n) put(BYTE_W'($urandom), 1'b1 == 1'b0);
            force_first = 1'b1;
        end else if (kind < 85) begin
            put({CONT_TAG, CONT_W'($urandom_range(63))}, fos);
        end else if (kind < 92) begin
            // Truncated sequence; usually cut by a new string, else finished later.
            if ($urandom_range(1) == 1) begin
                put({NIB_LEAD3, 4'($urandom_range(15))}, fos);
                if ($urandom_range(1) == 1) begin
                    put(cont_byte(), 1'b0);
                end
            end else begin
                put({NIB_LEAD2A[3:1], 5'($urandom_range(31))}, fos);
            end
            force_first = ($urandom_range(3) != 0);
        end else begin
            put(BYTE_W'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int phase_end;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed part, no idling ----
        put(8'h00, 1'b1);                      // lowest ASCII
        put(8'h7F, 1'b0);                      // highest ASCII
        put(8'hC0, 1'b0); put(8'h80, 1'b0);    // two-byte, all zero
        put(8'hDF, 1'b0); put(8'hBF, 1'b0);    // two-byte max, 110x lead with x=1
        put(8'hE0, 1'b0); put(8'h80, 1'b0); put(8'h80, 1'b0);
        put(8'hEF, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0);  // 0xFFFF
        // continuation bytes with wrong top bits still used for their low 6
        put(8'hE1, 1'b0); put(8'h41, 1'b0); put(8'hFF, 1'b0);
        put(8'h80, 1'b0); put(8'hBF, 1'b0);    // stray continuations
        put(8'hF0, 1'b0);                      // four-byte lead aborts the string
        put(8'h41, 1'b0); put(8'hC3, 1'b0);    // dropped
        put(8'h41, 1'b1);                      // new string clears the abort
        put(8'hE2, 1'b0); put(8'h42, 1'b1);    // new string mid-sequence
        put(8'hC5, 1'b0); put(8'hF7, 1'b1);    // abort right at a string start
        put(8'hC3, 1'b1); put(8'hA9, 1'b0);    // two-byte sequence at a string start

        // ---- random part, four idling phases ----
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 34; snk_stall_pct = 34; end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                send_random_unit();
            end
        end
        s_valid <= 1'b0;

        // Drain: wait for every expected character, then let the buffer settle.
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.outstanding() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", sb.outstanding()));
        end
        if (mismatches == 0) begin
            $display("utf8_to_ucs2_decoder_core_tb: done, clean");
        end else begin
            $display("utf8_to_ucs2_decoder_core_tb: done, errors");
        end
        $finish;
    end

endmodule
